FILE: rtl/cartesian_to_spherical_unit_assert.svh
// assertion macros for the cartesian to spherical unit
// expects clk and rst in the scope of each use
`ifndef CARTESIAN_TO_SPHERICAL_UNIT_ASSERT_SVH
`define CARTESIAN_TO_SPHERICAL_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define C2S_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("c2s assertion failed");

// condition must never hold
`define C2S_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("c2s assertion failed");

`endif

FILE: rtl/c2s_pkg.sv
// shared types and constants for the cartesian to spherical unit
// no dependencies
`default_nettype none

package c2s_pkg;

  // root width of the square root pipelines
  localparam int SQRT_W = 32;
  // cordic datapath and angle accumulator widths
  localparam int CW    = 56;
  localparam int ANG_W = 36;

  localparam logic signed [ANG_W-1:0] PI_Q30      = 36'sd3373259426;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 36'sd1686629713;
  // 180/pi scaled by 2^24
  localparam logic signed [31:0] DEG_PER_RAD_Q24 = 32'sd961263669;

  // flags and radius that travel beside the cordic lanes
  typedef struct packed {
    logic        hzero;
    logic        zpos;
    logic        zneg;
    logic [23:0] radius;
  } side_t;

  // arctangent of 2^-i in radians Q2.30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/c2s_isqrt.sv
// pipelined integer square root, one root bit per stage
// depends on nothing but its parameters
`default_nettype none

module c2s_isqrt #(
  parameter int ROOT_W = 32,
  parameter int SIDE_W = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [2*ROOT_W-1:0]   in_rad,
  input  wire logic [SIDE_W-1:0]     in_side,
  output logic                       out_valid,
  output logic [ROOT_W-1:0]          out_root,
  output logic [ROOT_W:0]            out_rem,
  output logic [SIDE_W-1:0]          out_side
);

  logic                  vld  [0:ROOT_W];
  logic [2*ROOT_W-1:0]   rad  [0:ROOT_W];
  logic [ROOT_W-1:0]     root [0:ROOT_W];
  logic [ROOT_W+1:0]     rem  [0:ROOT_W];
  logic [SIDE_W-1:0]     side [0:ROOT_W];

  // stage zero is the input itself
  assign vld[0]  = in_valid;
  assign rad[0]  = in_rad;
  assign root[0] = '0;
  assign rem[0]  = '0;
  assign side[0] = in_side;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    localparam int BP = 2 * (ROOT_W - 1 - s);
    logic [ROOT_W+1:0] cur;
    logic [ROOT_W+1:0] trial;
    logic              take;

    // bring down two radicand bits and try the next root bit
    always_comb begin
      cur   = {rem[s][ROOT_W-1:0], rad[s][BP +: 2]};
      trial = {root[s], 2'b01};
      take  = (cur >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      rad[s+1]  <= rad[s];
      side[s+1] <= side[s];
      if (take) begin
        rem[s+1]  <= cur - trial;
        root[s+1] <= {root[s][ROOT_W-2:0], 1'b1};
      end else begin
        rem[s+1]  <= cur;
        root[s+1] <= {root[s][ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign out_root  = root[ROOT_W];
  assign out_rem   = rem[ROOT_W][ROOT_W:0];
  assign out_side  = side[ROOT_W];

endmodule

`default_nettype wire

FILE: rtl/c2s_cordic.sv
// pipelined vectoring cordic, one rotation per stage
// depends on c2s_pkg for widths and the arctangent constants
`default_nettype none

module c2s_cordic #(
  parameter int STAGES = 22,
  parameter int SIDE_W = 1
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  input  wire logic signed [c2s_pkg::CW-1:0]    in_x,
  input  wire logic signed [c2s_pkg::CW-1:0]    in_y,
  input  wire logic signed [c2s_pkg::ANG_W-1:0] in_acc,
  input  wire logic [SIDE_W-1:0]              in_side,
  output logic                                out_valid,
  output logic signed [c2s_pkg::ANG_W-1:0]      out_acc,
  output logic [SIDE_W-1:0]                   out_side
);

  logic                              vld  [0:STAGES];
  logic signed [c2s_pkg::CW-1:0]     xs   [0:STAGES];
  logic signed [c2s_pkg::CW-1:0]     ys   [0:STAGES];
  logic signed [c2s_pkg::ANG_W-1:0]  acc  [0:STAGES];
  logic [SIDE_W-1:0]                 side [0:STAGES];

  assign vld[0]  = in_valid;
  assign xs[0]   = in_x;
  assign ys[0]   = in_y;
  assign acc[0]  = in_acc;
  assign side[0] = in_side;

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    localparam logic [4:0] IDX = 5'(s);
    logic signed [c2s_pkg::CW-1:0]    sx;
    logic signed [c2s_pkg::CW-1:0]    sy;
    logic signed [c2s_pkg::ANG_W-1:0] ang;
    logic                             up;

    // rotate toward y = 0, y >= 0 counts as positive
    always_comb begin
      sx  = xs[s] >>> s;
      sy  = ys[s] >>> s;
      ang = {{(c2s_pkg::ANG_W-32){1'b0}}, c2s_pkg::atan_q30(IDX)};
      up  = ~ys[s][c2s_pkg::CW-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      side[s+1] <= side[s];
      if (up) begin
        xs[s+1]  <= xs[s] + sy;
        ys[s+1]  <= ys[s] - sx;
        acc[s+1] <= acc[s] + ang;
      end else begin
        xs[s+1]  <= xs[s] - sy;
        ys[s+1]  <= ys[s] + sx;
        acc[s+1] <= acc[s] - ang;
      end
    end
  end

  assign out_valid = vld[STAGES];
  assign out_acc   = acc[STAGES];
  assign out_side  = side[STAGES];

endmodule

`default_nettype wire

FILE: rtl/cartesian_to_spherical_unit.sv
// cartesian to spherical conversion, top level
// depends on c2s_pkg, c2s_isqrt, c2s_cordic and the assertion macro header
//
// usage:
//   a request is taken on every rising edge with start high; busy stays low,
//   so one point per cycle is sustained. coord_x/y/z are signed Q12.12.
//   each result shows on radius, azimuth and elevation for one cycle with
//   done high, after it has passed the input, square and sum registers, 32
//   square root stages, one cordic stage per rotation and the angle
//   scaling and output registers.
//   results come out in request order; the receiver has no way to stall.
//   angles are radians Q3.20 when angle_in_degrees is 0, degrees Q9.14
//   when it is 1; the register is written with cfg_wr_en and cfg_wr_data
//   and should only change while no request is in flight.
//   radius is unsigned Q12.12, rounded to nearest and saturating.
//   rst is synchronous; it clears every valid bit in flight and the mode
//   register goes back to radians.
`default_nettype none

module cartesian_to_spherical_unit #(
  parameter int CORDIC_STAGES = 22
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [23:0] coord_x,
  input  wire logic signed [23:0] coord_y,
  input  wire logic signed [23:0] coord_z,
  input  wire logic               cfg_wr_en,
  input  wire logic               cfg_wr_data,
  output logic                    done,
  output logic [23:0]             radius,
  output logic signed [23:0]      azimuth,
  output logic signed [23:0]      elevation
);

  localparam int LATENCY = CORDIC_STAGES + 37;
  localparam int SIDE_W  = $bits(c2s_pkg::side_t);
  localparam int SW      = c2s_pkg::SQRT_W;
  localparam int AW      = c2s_pkg::ANG_W;
  localparam int PW      = c2s_pkg::ANG_W + 32;

  logic angle_in_degrees;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_in_degrees <= 1'b0;
    end else if (cfg_wr_en) begin
      angle_in_degrees <= cfg_wr_data;
    end
  end

  assign busy = 1'b0;

  // input registers
  logic               v1;
  logic signed [23:0] x1, y1, z1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    x1 <= coord_x;
    y1 <= coord_y;
    z1 <= coord_z;
  end

  // squares
  logic               v2;
  logic signed [23:0] x2, y2, z2;
  logic [47:0]        xx, yy, zz;
  logic signed [47:0] xx_next, yy_next, zz_next;

  always_comb begin
    xx_next = x1 * x1;
    yy_next = y1 * y1;
    zz_next = z1 * z1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    x2 <= x1;
    y2 <= y1;
    z2 <= z1;
    xx <= xx_next;
    yy <= yy_next;
    zz <= zz_next;
  end

  // sums of squares, both stay below 2^48
  logic               v3;
  logic signed [23:0] x3, y3, z3;
  logic [47:0]        hsq, ssq;
  logic               hz3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    x3  <= x2;
    y3  <= y2;
    z3  <= z2;
    hsq <= xx + yy;
    ssq <= xx + yy + zz;
    hz3 <= (x2 == '0) && (y2 == '0);
  end

  // square roots: total radius in input units, horizontal length in 2^-20 units
  logic          sq_valid;
  logic [SW-1:0] r_root, rho;
  logic [SW:0]   r_rem;
  logic [SW:0]   rho_rem;
  logic [71:0]   sq_xyz;
  logic          sq_hz;

  c2s_isqrt #(.ROOT_W(SW), .SIDE_W(1)) u_sqrt_r (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .in_rad   ({16'b0, ssq}),
    .in_side  (hz3),
    .out_valid(sq_valid),
    .out_root (r_root),
    .out_rem  (r_rem),
    .out_side (sq_hz)
  );

  c2s_isqrt #(.ROOT_W(SW), .SIDE_W(72)) u_sqrt_rho (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v3),
    .in_rad   ({hsq, 16'b0}),
    .in_side  ({x3, y3, z3}),
    .out_valid(),
    .out_root (rho),
    .out_rem  (rho_rem),
    .out_side (sq_xyz)
  );

  // radius rounding, cordic start vectors and special-case flags
  logic signed [23:0]          sx, sy, sz;
  logic signed [c2s_pkg::CW-1:0] ax, ay, ex, ey;
  logic signed [AW-1:0]        az0;
  logic [24:0]                 r_up;
  c2s_pkg::side_t              side_in, side_out;
  logic                        el_zpos;

  always_comb begin
    sx = sq_xyz[71:48];
    sy = sq_xyz[47:24];
    sz = sq_xyz[23:0];
    r_up = r_root[24:0] + {24'b0, (r_rem > {1'b0, r_root})};
    side_in.hzero  = sq_hz;
    side_in.zpos   = ~sz[23] & (sz != '0);
    side_in.zneg   = sz[23];
    side_in.radius = r_up[24] ? 24'hFFFFFF : r_up[23:0];
    ax = {{4{sx[23]}}, sx, 28'b0};
    ay = {{4{sy[23]}}, sy, 28'b0};
    az0 = '0;
    if (sx[23]) begin
      ax  = -ax;
      ay  = -ay;
      az0 = sy[23] ? -c2s_pkg::PI_Q30 : c2s_pkg::PI_Q30;
    end
    ex = {4'b0, rho, 20'b0};
    ey = {{4{sz[23]}}, sz, 28'b0};
  end

  logic                 cd_valid;
  logic signed [AW-1:0] az_acc, el_acc;

  c2s_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(SIDE_W)) u_cordic_az (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sq_valid),
    .in_x     (ax),
    .in_y     (ay),
    .in_acc   (az0),
    .in_side  (side_in),
    .out_valid(cd_valid),
    .out_acc  (az_acc),
    .out_side (side_out)
  );

  c2s_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_cordic_el (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sq_valid),
    .in_x     (ex),
    .in_y     (ey),
    .in_acc   ('0),
    .in_side  (side_in.zpos),
    .out_valid(),
    .out_acc  (el_acc),
    .out_side (el_zpos)
  );

  // axis overrides, then scale to degrees
  logic                 vm;
  logic signed [AW-1:0] az_f, el_f;
  logic signed [AW-1:0] az_m, el_m;
  logic signed [PW-1:0] az_p, el_p;
  logic [23:0]          rad_m;

  always_comb begin
    az_f = side_out.hzero ? '0 : az_acc;
    el_f = el_acc;
    if (side_out.hzero) begin
      if (el_zpos) begin
        el_f = c2s_pkg::HALF_PI_Q30;
      end else if (side_out.zneg) begin
        el_f = -c2s_pkg::HALF_PI_Q30;
      end else begin
        el_f = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else begin
      vm <= cd_valid;
    end
  end

  always_ff @(posedge clk) begin
    az_m  <= az_f;
    el_m  <= el_f;
    az_p  <= az_f * c2s_pkg::DEG_PER_RAD_Q24;
    el_p  <= el_f * c2s_pkg::DEG_PER_RAD_Q24;
    rad_m <= side_out.radius;
  end

  // rounding and output registers
  logic signed [AW-1:0] az_r, el_r;
  logic signed [PW-1:0] az_d, el_d;

  always_comb begin
    az_r = az_m + AW'(512);
    el_r = el_m + AW'(512);
    az_d = az_p + (PW'(1) <<< 39);
    el_d = el_p + (PW'(1) <<< 39);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vm;
    end
  end

  always_ff @(posedge clk) begin
    radius <= rad_m;
    if (angle_in_degrees) begin
      azimuth   <= az_d[63:40];
      elevation <= el_d[63:40];
    end else begin
      azimuth   <= az_r[33:10];
      elevation <= el_r[33:10];
    end
  end

  // checks
  `include "cartesian_to_spherical_unit_assert.svh"

  `C2S_ASSERT_IMP(a_done_has_request, done, $past(start, LATENCY))
  `C2S_ASSERT_IMP(a_origin_zero, done && (radius == '0), (azimuth == '0) && (elevation == '0))
  `C2S_ASSERT_NEVER(a_never_busy, busy && done)

endmodule

`default_nettype wire

FILE: verif/cartesian_to_spherical_unit_tb.sv
// self-checking testbench for cartesian_to_spherical_unit
// drives directed and random points, predicts radius, azimuth, elevation
// depends on the cartesian_to_spherical_unit rtl only
`timescale 1ns / 1ps
`default_nettype none

module cartesian_to_spherical_unit_tb;

  localparam int STAGES = 22;
  localparam int DRAIN_CYCLES = STAGES + 37 + 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_PRINTS = 30;

  // expected spherical coordinates of one point
  typedef struct {
    logic signed [23:0] px;
    logic signed [23:0] py;
    logic signed [23:0] pz;
    logic [23:0]        rad;
    logic [23:0]        azi;
    logic [23:0]        ele;
  } sph_point_t;

  // converts points and keeps the results still due from the unit
  class sph_scoreboard;
    sph_point_t pending[$];
    bit         deg_mode;
    int         errors;
    int         checked;
    int         noted;

    localparam longint ATAN_Q30[32] = '{
      64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
      64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
      64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
      64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
      64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
      64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002,
      64'h00000001, 64'h00000000};

    function longint unsigned sqrt_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
        if (v >= res + bt) begin
          v = v - (res + bt);
          res = (res >> 1) + bt;
        end else begin
          res = res >> 1;
        end
        bt = bt >> 2;
      end
      return res;
    endfunction

    // vectoring rotation, angle of (a, b) in radians Q2.30
    function longint vector_angle(longint b, longint a);
      longint acc;
      longint xs;
      longint ys;
      longint nx;
      longint ny;
      acc = 0;
      if (a < 0) begin
        acc = (b >= 0) ? 64'sd3373259426 : -64'sd3373259426;
        a = -a;
        b = -b;
      end
      xs = a * 64'sd1048576;
      ys = b * 64'sd1048576;
      for (int i = 0; i < STAGES && i < 32; i++) begin
        if (ys >= 0) begin
          nx = xs + (ys >>> i);
          ny = ys - (xs >>> i);
          acc = acc + ATAN_Q30[i];
        end else begin
          nx = xs - (ys >>> i);
          ny = ys + (xs >>> i);
          acc = acc - ATAN_Q30[i];
        end
        xs = nx;
        ys = ny;
      end
      return acc;
    endfunction

    // radians Q3.20 or degrees Q9.14, rounded half up
    function logic [23:0] scale_angle(longint a);
      longint r;
      if (deg_mode) r = (a * 64'sd961263669 + (64'sd1 <<< 39)) >>> 40;
      else r = (a + 512) >>> 10;
      return r[23:0];
    endfunction

    function void note(logic signed [23:0] cx, logic signed [23:0] cy,
                       logic signed [23:0] cz);
      sph_point_t p;
      longint x;
      longint y;
      longint z;
      longint unsigned hsq;
      longint unsigned ssq;
      longint unsigned r;
      longint rho;
      longint az;
      longint el;
      x = cx;
      y = cy;
      z = cz;
      hsq = x * x + y * y;
      ssq = hsq + z * z;
      r = sqrt_floor(ssq);
      if (ssq - r * r > r) r = r + 1;
      if (r > 64'hFFFFFF) r = 64'hFFFFFF;
      if (x == 0 && y == 0) begin
        az = 0;
        if (z > 0) el = 64'sd1686629713;
        else if (z < 0) el = -64'sd1686629713;
        else el = 0;
      end else begin
        rho = sqrt_floor(hsq << 16);
        az = vector_angle(y * 256, x * 256);
        el = vector_angle(z * 256, rho);
      end
      p.px = cx;
      p.py = cy;
      p.pz = cz;
      p.rad = r[23:0];
      p.azi = scale_angle(az);
      p.ele = scale_angle(el);
      pending.push_back(p);
      noted++;
    endfunction

    function void report(string what, sph_point_t p, logic [23:0] want,
                         logic [23:0] got);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("mismatch %s for point (%0d,%0d,%0d): expected %h got %h",
                 what, p.px, p.py, p.pz, want, got);
    endfunction

    function void check(logic [23:0] rad, logic [23:0] azi, logic [23:0] ele);
      sph_point_t p;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= MAX_PRINTS) $display("result with no request pending");
        return;
      end
      p = pending.pop_front();
      checked++;
      if (rad !== p.rad) report("radius", p, p.rad, rad);
      if (azi !== p.azi) report("azimuth", p, p.azi, azi);
      if (ele !== p.ele) report("elevation", p, p.ele, ele);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [23:0] coord_x;
  logic signed [23:0] coord_y;
  logic signed [23:0] coord_z;
  logic cfg_wr_en;
  logic cfg_wr_data;
  logic done;
  logic [23:0] radius;
  logic signed [23:0] azimuth;
  logic signed [23:0] elevation;

  sph_scoreboard sb;
  bit accepted;
  int idle_cycles;

  cartesian_to_spherical_unit #(.CORDIC_STAGES(STAGES)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .done(done), .radius(radius), .azimuth(azimuth), .elevation(elevation)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // result monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check(radius, azimuth, elevation);
      if (done || accepted) idle_cycles = 0;
      else idle_cycles++;
      accepted = 0;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results pending", sb.pending.size());
        $display("cartesian_to_spherical_unit test failed");
        $finish;
      end
    end
  end

  // one request, after a random gap unless back to back is asked
  task send_point(logic signed [23:0] vx, logic signed [23:0] vy,
                  logic signed [23:0] vz, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    coord_x <= vx;
    coord_y <= vy;
    coord_z <= vz;
    do @(posedge clk); while (busy);
    accepted = 1;
    sb.note(vx, vy, vz);
  endtask

  // hold off until every pending result is back, then let the pipe empty
  task drain;
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task set_mode(bit deg);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= deg;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.deg_mode = deg;
  endtask

  function logic signed [23:0] rand_coord(int kind);
    logic [31:0] w;
    w = $urandom;
    case (kind)
      0: return w[23:0];
      1: return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
      2: return 24'sd0;
      3: return w[0] ? 24'sh7FFFFF : 24'sh800000;
      default: return $signed(24'($urandom_range(0, 511))) - 24'sd256;
    endcase
  endfunction

  task random_points(int count);
    bit burst;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
      send_point(rand_coord($urandom_range(0, 4) == 0 ? $urandom_range(1, 4) : 0),
                 rand_coord($urandom_range(0, 4) == 0 ? $urandom_range(1, 4) : 0),
                 rand_coord($urandom_range(0, 4) == 0 ? $urandom_range(1, 4) : 0),
                 burst);
    end
  endtask

  task directed_points;
    send_point(24'sd0, 24'sd0, 24'sd0, 0);
    send_point(24'sd0, 24'sd0, 24'sh7FFFFF, 0);
    send_point(24'sd0, 24'sd0, 24'sh800000, 1);
    send_point(24'sd0, 24'sd0, 24'sd1, 1);
    send_point(24'sd0, 24'sd0, -24'sd1, 0);
    send_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0);
    send_point(24'sh800000, 24'sh800000, 24'sh800000, 1);
    send_point(24'sh800000, 24'sd0, 24'sd0, 0);
    send_point(-24'sd1, 24'sd0, 24'sd0, 0);
    send_point(-24'sd1, -24'sd1, 24'sd0, 0);
    send_point(-24'sd4096, 24'sd1, 24'sd5, 1);
    send_point(24'sd1, 24'sd0, 24'sd0, 0);
    send_point(24'sd0, 24'sd1, 24'sd0, 0);
    send_point(24'sd0, -24'sd1, 24'sd0, 0);
    send_point(24'sh7FFFFF, 24'sh800000, 24'sd0, 0);
    send_point(24'sh800000, 24'sh7FFFFF, 24'sh800000, 0);
    send_point(24'sd1, 24'sd1, 24'sd1, 1);
    send_point(24'sd4096, 24'sd4096, -24'sd4096, 0);
    send_point(24'sd3, 24'sd4, 24'sd0, 0);
    send_point(24'sd1, 24'sd0, 24'sh7FFFFF, 0);
  endtask

  initial begin
    sb = new();
    accepted = 0;
    idle_cycles = 0;
    rst = 1'b1;
    start = 1'b0;
    coord_x = '0;
    coord_y = '0;
    coord_z = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // radians, then degrees, over directed and random points
    set_mode(1'b0);
    directed_points();
    drain();
    set_mode(1'b1);
    directed_points();
    random_points(250);
    drain();
    set_mode(1'b0);
    random_points(250);
    drain();
    set_mode(1'b1);
    random_points(250);
    drain();

    $display("converted %0d points, %0d results checked, both angle units",
             sb.noted, sb.checked);
    if (sb.pending.size() != 0) begin
      sb.errors++;
      $display("%0d results never arrived", sb.pending.size());
    end
    if (sb.errors == 0) begin
      $display("cartesian_to_spherical_unit test passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("cartesian_to_spherical_unit test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/c2s_pkg.sv
rtl/c2s_isqrt.sv
rtl/c2s_cordic.sv
rtl/cartesian_to_spherical_unit.sv
verif/cartesian_to_spherical_unit_tb.sv
